FILE: rtl/core/stb_pkg.sv
`default_nettype none

package stb_pkg;

   localparam int TIMER_SLOTS_DEFAULT = 32;
   localparam int TIME_WIDTH_DEFAULT  = 32;

   localparam int CMD_W     = 2;
   localparam int ID_W      = 5;
   localparam int START_W   = 31;
   localparam int IVAL_W    = 31;
   localparam int ELAPSED_W = 16;
   localparam int STATUS_W  = 3;
   localparam int COUNT_W   = 6;

   typedef enum logic [CMD_W-1:0] {
      CMD_START = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_QUERY = 2'd3
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_STARTED      = 3'd0,
      ST_START_REFUSE = 3'd1,
      ST_START_IGNORE = 3'd2,
      ST_STOPPED      = 3'd3,
      ST_STOP_REFUSE  = 3'd4,
      ST_EXPIRY       = 3'd5,
      ST_TICK_DONE    = 3'd6,
      ST_QUERY        = 3'd7
   } status_type;

   // per-cell strobes from the sequencer
   typedef struct packed {
      logic start_en;
      logic stop_en;
      logic free_en;
      logic shift_en;
   } cell_ctrl_type;

   // per-cell flags back to the sequencer
   typedef struct packed {
      logic valid;
      logic pend;
      logic tok;
      logic expire;
      logic mark;
   } cell_stat_type;

endpackage

`default_nettype wire

FILE: rtl/core/stb_timer_cell.sv
`default_nettype none

module stb_timer_cell #(
   parameter int TIME_WIDTH = stb_pkg::TIME_WIDTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire stb_pkg::cell_ctrl_type          ctrl,
   input  wire logic                            tok_in,
   input  wire logic [stb_pkg::START_W-1:0]     start_remaining,
   input  wire logic [stb_pkg::IVAL_W-1:0]      interval,
   input  wire logic                            periodic,
   input  wire logic [stb_pkg::ELAPSED_W-1:0]   elapsed,
   output      stb_pkg::cell_stat_type          stat
);
   import stb_pkg::*;

   localparam int W  = TIME_WIDTH;
   localparam int EW = ((W > 32) ? W : 32) + 2;
   localparam logic signed [EW-1:0] TMAX = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [EW-1:0] TMIN = {{(EW-W+1){1'b1}}, {(W-1){1'b0}}};

   logic                valid_ff, valid_in;
   logic                pend_ff, pend_in;
   logic                tok_ff, tok_in_nxt;
   logic signed [W-1:0] rem_ff, rem_in;
   logic [IVAL_W-1:0]   ival_ff, ival_in;
   logic                per_ff, per_in;

   logic signed [EW-1:0] rem_e, el_e, ival_e, start_e;
   logic signed [EW-1:0] diff, dsat, sum, ssat, start_sat, rnext;
   logic                 neg, visit;

   always_comb begin
      rem_e   = {{(EW-W){rem_ff[W-1]}}, rem_ff};
      el_e    = {{(EW-ELAPSED_W){1'b0}}, elapsed};
      ival_e  = {{(EW-IVAL_W){1'b0}}, ival_ff};
      start_e = {{(EW-START_W){1'b0}}, start_remaining};
      // subtract elapsed, clamp at the negative bound
      diff    = rem_e - el_e;
      dsat    = (diff < TMIN) ? TMIN : diff;
      neg     = dsat[EW-1];
      // reload by the interval, clamp at the positive bound
      sum     = dsat + ival_e;
      ssat    = (sum > TMAX) ? TMAX : sum;
      rnext   = neg ? ssat : dsat;
      start_sat = (start_e > TMAX) ? TMAX : start_e;
   end

   assign visit = tok_ff && ctrl.shift_en && valid_ff;

   always_comb begin
      valid_in   = valid_ff;
      pend_in    = pend_ff;
      rem_in     = rem_ff;
      ival_in    = ival_ff;
      per_in     = per_ff;
      tok_in_nxt = ctrl.shift_en ? tok_in : tok_ff;
      if (ctrl.free_en) begin
         if (pend_ff) valid_in = 1'b0;
         pend_in = 1'b0;
      end
      if (ctrl.start_en) begin
         valid_in = 1'b1;
         pend_in  = 1'b0;
         rem_in   = start_sat[W-1:0];
         ival_in  = interval;
         per_in   = periodic;
      end
      if (ctrl.stop_en) pend_in = 1'b1;
      if (visit) begin
         rem_in = rnext[W-1:0];
         if (neg && !per_ff) pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
         tok_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
         tok_ff   <= tok_in_nxt;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      ival_ff <= ival_in;
      per_ff  <= per_in;
   end

   assign stat.valid  = valid_ff;
   assign stat.pend   = pend_ff;
   assign stat.tok    = tok_ff;
   assign stat.expire = tok_ff && valid_ff && neg;
   assign stat.mark   = tok_ff && valid_ff && neg && !per_ff;

endmodule

`default_nettype wire

FILE: rtl/core/software_timer_bank_core.sv
`default_nettype none
// Bank of one-shot and periodic millisecond timers, one cell per slot, timer id = slot.
// Input channel req_*: one beat carries a command (start, stop, tick, query) and its
// operands. Result channel rsp_*: start, stop and query give one beat each, loaded
// into the output register in the cycle the command is taken. A tick gives one
// expiry beat per expiring slot, in ascending slot order, then a tick-done beat with
// the active count; rsp_last marks the final beat of every command.
// A tick takes the beat and frees marked slots, then a token walks the chain of slot
// cells from cell 0 to the last, then a final step frees marked slots and gives tick
// done. Other commands complete when they are taken.
// The token waits while the output register is held by a stalled receiver, so a
// stall lengthens the tick; no beat is dropped.
// req_ready is high only when the sequencer is idle and the output register is free
// or being emptied in the same cycle.
// Reset (synchronous) empties every slot, clears the counters and drops any beat
// held in the output register.
module software_timer_bank_core #(
   parameter int TIMER_SLOTS = stb_pkg::TIMER_SLOTS_DEFAULT,
   parameter int TIME_WIDTH  = stb_pkg::TIME_WIDTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic [stb_pkg::CMD_W-1:0]      req_command,
   input  wire logic [stb_pkg::ID_W-1:0]       req_timer_id,
   input  wire logic [stb_pkg::START_W-1:0]    req_start_remaining,
   input  wire logic [stb_pkg::IVAL_W-1:0]     req_interval,
   input  wire logic                           req_periodic,
   input  wire logic [stb_pkg::ELAPSED_W-1:0]  req_elapsed_ms,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic [stb_pkg::STATUS_W-1:0]   rsp_status,
   output      logic [stb_pkg::ID_W-1:0]       rsp_event_id,
   output      logic                           rsp_is_active,
   output      logic [stb_pkg::COUNT_W-1:0]    rsp_active_count,
   output      logic                           rsp_last
);
   import stb_pkg::*;

   localparam int N  = TIMER_SLOTS;
   localparam int CW = $clog2(N + 1);
   localparam int IW = (N > 1) ? $clog2(N) : 1;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_WALK = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         pcnt_ff, pcnt_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [ELAPSED_W-1:0]  el_ff, el_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic                  rsp_act_ff, rsp_act_in;
   logic [COUNT_W-1:0]    rsp_cnt_ff, rsp_cnt_in;
   logic                  rsp_last_ff, rsp_last_in;

   cell_ctrl_type ctrl [N];
   cell_stat_type stat [N];
   logic [N-1:0]  hit, tok_vec, exp_vec, mark_vec, valid_vec, pend_vec;

   logic adv, fire, in_range, sel_valid, sel_pend, active;
   logic start_fire, stop_fire, tick_fire, start_ok, stop_ok;
   logic walk_step, done_step, any_exp, any_mark;
   command_type cmd;

   assign cmd        = command_type'(req_command);
   assign adv        = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == S_IDLE) && adv;
   assign fire       = req_valid && req_ready;
   assign start_fire = fire && (cmd == CMD_START);
   assign stop_fire  = fire && (cmd == CMD_STOP);
   assign tick_fire  = fire && (cmd == CMD_TICK);
   assign walk_step  = (state_ff == S_WALK) && adv;
   assign done_step  = (state_ff == S_DONE) && adv;
   assign in_range   = {{(32-ID_W){1'b0}}, req_timer_id} < 32'(N);
   assign sel_valid  = in_range && |(hit & valid_vec);
   assign sel_pend   = in_range && |(hit & pend_vec);
   assign active     = sel_valid && !sel_pend;
   assign start_ok   = in_range && !sel_valid;
   assign stop_ok    = active;
   assign any_exp    = |exp_vec;
   assign any_mark   = |mark_vec;

   for (genvar g = 0; g < N; g++) begin : g_cell
      assign hit[g]       = {{(32-ID_W){1'b0}}, req_timer_id} == 32'(g);
      assign tok_vec[g]   = stat[g].tok;
      assign exp_vec[g]   = stat[g].expire;
      assign mark_vec[g]  = stat[g].mark;
      assign valid_vec[g] = stat[g].valid;
      assign pend_vec[g]  = stat[g].pend;

      assign ctrl[g].start_en = start_fire && hit[g] && start_ok;
      assign ctrl[g].stop_en  = stop_fire && hit[g] && stop_ok;
      assign ctrl[g].free_en  = tick_fire || done_step;
      assign ctrl[g].shift_en = tick_fire || walk_step;

      stb_timer_cell #(
         .TIME_WIDTH(TIME_WIDTH)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .ctrl            (ctrl[g]),
         .tok_in          ((g == 0) ? tick_fire : tok_vec[(g == 0) ? 0 : g - 1]),
         .start_remaining (req_start_remaining),
         .interval        (req_interval),
         .periodic        (req_periodic),
         .elapsed         (el_ff),
         .stat            (stat[g])
      );
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pcnt_in       = pcnt_ff;
      idx_in        = idx_ff;
      el_in         = el_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_act_in    = rsp_act_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (fire) begin
               rsp_id_in   = req_timer_id;
               rsp_act_in  = 1'b0;
               rsp_cnt_in  = COUNT_W'(count_ff);
               rsp_last_in = 1'b1;
               case (cmd)
                  CMD_START: begin
                     rsp_valid_in = 1'b1;
                     if (!in_range || active) begin
                        rsp_status_in = ST_START_REFUSE;
                     end else if (sel_valid) begin
                        rsp_status_in = ST_START_IGNORE;
                     end else begin
                        rsp_status_in = ST_STARTED;
                        count_in      = count_ff + 1'b1;
                        rsp_cnt_in    = COUNT_W'(count_ff + 1'b1);
                     end
                  end
                  CMD_STOP: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = stop_ok ? ST_STOPPED : ST_STOP_REFUSE;
                     if (stop_ok) pcnt_in = pcnt_ff + 1'b1;
                  end
                  CMD_QUERY: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_QUERY;
                     rsp_act_in    = active;
                  end
                  CMD_TICK: begin
                     // free marked slots now, walk the chain from cell 0
                     count_in = count_ff - pcnt_ff;
                     pcnt_in  = '0;
                     el_in    = req_elapsed_ms;
                     idx_in   = '0;
                     state_in = S_WALK;
                  end
                  default: ;
               endcase
            end
         end
         S_WALK: begin
            if (adv) begin
               if (any_exp) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_EXPIRY;
                  rsp_id_in     = ID_W'(idx_ff);
                  rsp_act_in    = 1'b0;
                  rsp_cnt_in    = '0;
                  rsp_last_in   = 1'b0;
               end
               if (any_mark) pcnt_in = pcnt_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
               if (tok_vec[N-1]) state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (adv) begin
               count_in      = count_ff - pcnt_ff;
               pcnt_in       = '0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_TICK_DONE;
               rsp_id_in     = '0;
               rsp_act_in    = 1'b0;
               rsp_cnt_in    = COUNT_W'(count_ff - pcnt_ff);
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pcnt_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pcnt_ff      <= pcnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      el_ff         <= el_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_act_ff    <= rsp_act_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_event_id     = rsp_id_ff;
   assign rsp_is_active    = rsp_act_ff;
   assign rsp_active_count = rsp_cnt_ff;
   assign rsp_last         = rsp_last_ff;

   a_tok_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("more than one tick token in the cell chain");

   a_tok_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> $onehot(tok_vec))
      else $error("tick walk without a token");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (pcnt_ff <= count_ff) && (32'(count_ff) <= 32'(N)))
      else $error("slot counters out of range");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (32'(count_ff) == 32'($countones(valid_vec))))
      else $error("active count differs from valid cells");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
module testbench;
   import stb_pkg::*;

   localparam int          SLOTS        = TIMER_SLOTS_DEFAULT;
   localparam int          RANDOM_ITEMS = 420;
   localparam int          TAIL_CYCLES  = 2 * SLOTS;   // a tick walks every slot, plus margin
   localparam int          HOLD_CYCLES  = 400;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam longint      TIME_MAX     = 64'sd2147483647;
   localparam longint      TIME_MIN     = -TIME_MAX - 1;

   typedef struct {
      status_type         status;
      logic [ID_W-1:0]    event_id;
      logic               is_active;
      logic [COUNT_W-1:0] active_count;
      logic               last;
   } timer_beat_type;

   class timer_bank_tracker;
      bit             armed     [SLOTS];
      bit             doomed    [SLOTS];
      longint         remaining [SLOTS];
      longint         reload    [SLOTS];
      bit             repeats   [SLOTS];
      timer_beat_type due_beats [$];
      int             mismatches;

      function int held_count();
         int n = 0;
         foreach (armed[i]) if (armed[i]) n++;
         return n;
      endfunction

      function void free_doomed();
         foreach (armed[i]) begin
            if (doomed[i]) armed[i] = 1'b0;
            doomed[i] = 1'b0;
         end
      endfunction

      function void push_beat(status_type st, int id, bit act, int cnt, bit fin);
         timer_beat_type b;
         b.status       = st;
         b.event_id     = id[ID_W-1:0];
         b.is_active    = act;
         b.active_count = cnt[COUNT_W-1:0];
         b.last         = fin;
         due_beats.push_back(b);
      endfunction

      function void note_command(command_type cmd, logic [ID_W-1:0] id,
                                 logic [START_W-1:0] first, logic [IVAL_W-1:0] ival,
                                 logic per, logic [ELAPSED_W-1:0] el);
         bit         live;
         status_type st;
         longint     r;
         longint     lapse;
         live  = armed[id] && !doomed[id];
         lapse = {48'd0, el};
         case (cmd)
            CMD_START: begin
               if (live) begin
                  st = ST_START_REFUSE;
               end else if (armed[id]) begin
                  st = ST_START_IGNORE;
               end else begin
                  // a 31-bit start value never exceeds the time range
                  armed[id]     = 1'b1;
                  doomed[id]    = 1'b0;
                  remaining[id] = {33'd0, first};
                  reload[id]    = {33'd0, ival};
                  repeats[id]   = per;
                  st            = ST_STARTED;
               end
               push_beat(st, id, 1'b0, held_count(), 1'b1);
            end
            CMD_STOP: begin
               if (live) doomed[id] = 1'b1;
               push_beat(live ? ST_STOPPED : ST_STOP_REFUSE, id, 1'b0, held_count(), 1'b1);
            end
            CMD_QUERY: begin
               push_beat(ST_QUERY, id, live, held_count(), 1'b1);
            end
            default: begin
               free_doomed();
               foreach (armed[i]) begin
                  if (armed[i]) begin
                     r = (remaining[i] < TIME_MIN + lapse) ? TIME_MIN : remaining[i] - lapse;
                     if (r < 0) begin
                        push_beat(ST_EXPIRY, i, 1'b0, 0, 1'b0);
                        if (!repeats[i]) doomed[i] = 1'b1;
                        r = (r > TIME_MAX - reload[i]) ? TIME_MAX : r + reload[i];
                     end
                     remaining[i] = r;
                  end
               end
               free_doomed();
               push_beat(ST_TICK_DONE, 0, 1'b0, held_count(), 1'b1);
            end
         endcase
      endfunction

      function void check_beat(logic [STATUS_W-1:0] status, logic [ID_W-1:0] event_id,
                               logic is_active, logic [COUNT_W-1:0] active_count,
                               logic last);
         timer_beat_type want;
         if (due_beats.size() == 0) begin
            $error("unexpected beat: status %0d event_id %0d", status, event_id);
            mismatches++;
            return;
         end
         want = due_beats.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatches++;
         end
         if (event_id !== want.event_id) begin
            $error("event_id: expected %0d, got %0d", want.event_id, event_id);
            mismatches++;
         end
         if (is_active !== want.is_active) begin
            $error("is_active: expected %0d, got %0d", want.is_active, is_active);
            mismatches++;
         end
         if (active_count !== want.active_count) begin
            $error("active_count: expected %0d, got %0d", want.active_count, active_count);
            mismatches++;
         end
         if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            mismatches++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset               = 1'b1;
   logic                 req_valid           = 1'b0;
   logic                 req_ready;
   logic [CMD_W-1:0]     req_command         = '0;
   logic [ID_W-1:0]      req_timer_id        = '0;
   logic [START_W-1:0]   req_start_remaining = '0;
   logic [IVAL_W-1:0]    req_interval        = '0;
   logic                 req_periodic        = 1'b0;
   logic [ELAPSED_W-1:0] req_elapsed_ms      = '0;
   logic                 rsp_valid;
   logic                 rsp_ready           = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [ID_W-1:0]      rsp_event_id;
   logic                 rsp_is_active;
   logic [COUNT_W-1:0]   rsp_active_count;
   logic                 rsp_last;

   timer_bank_tracker bank = new();

   int          idle_pct    = 0;
   int          stall_pct   = 0;
   int          items_sent  = 0;
   int          hold_asked  = 0;
   int          hold_served = 0;
   int          hold_left   = 0;
   int unsigned cycle_count = 0;

   software_timer_bank_core u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_served) begin
         hold_served <= hold_asked;
         hold_left   <= HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         bank.note_command(command_type'(req_command), req_timer_id, req_start_remaining,
                           req_interval, req_periodic, req_elapsed_ms);
      if (!reset && rsp_valid && rsp_ready)
         bank.check_beat(rsp_status, rsp_event_id, rsp_is_active, rsp_active_count, rsp_last);
   end

   function automatic logic [START_W-1:0] pick_time();
      int unsigned pick = $urandom_range(99);
      if (pick < 10) return '0;
      if (pick < 20) return '1;
      if (pick < 35) return START_W'($urandom);
      return START_W'($urandom_range(300));
   endfunction

   function automatic logic [ELAPSED_W-1:0] pick_lapse();
      int unsigned pick = $urandom_range(99);
      if (pick < 10) return '0;
      if (pick < 20) return '1;
      if (pick < 30) return ELAPSED_W'($urandom);
      return ELAPSED_W'($urandom_range(200));
   endfunction

   // valid stays high across back-to-back beats; drop it only for a gap
   task automatic send_item(command_type cmd, logic [ID_W-1:0] id, logic [START_W-1:0] first,
                            logic [IVAL_W-1:0] ival, logic per, logic [ELAPSED_W-1:0] el);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid           <= 1'b1;
      req_command         <= cmd;
      req_timer_id        <= id;
      req_start_remaining <= first;
      req_interval        <= ival;
      req_periodic        <= per;
      req_elapsed_ms      <= el;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_random();
      int unsigned pick = $urandom_range(99);
      int unsigned id   = $urandom_range(1) ? $urandom_range(7) : $urandom_range(31);
      command_type cmd;
      cmd = pick < 35 ? CMD_START : pick < 50 ? CMD_STOP : pick < 78 ? CMD_TICK : CMD_QUERY;
      send_item(cmd, ID_W'(id), pick_time(), pick_time(), 1'($urandom), pick_lapse());
   endtask

   // empty the bank, arm every slot with a tiny count, then fire them all in one tick
   task automatic fill_bank();
      for (int i = 0; i < SLOTS; i++)
         send_item(CMD_STOP, ID_W'(i), pick_time(), pick_time(), 1'($urandom), pick_lapse());
      send_item(CMD_TICK, '0, pick_time(), pick_time(), 1'($urandom), '0);
      for (int i = 0; i < SLOTS; i++)
         send_item(CMD_START, ID_W'(i), START_W'($urandom_range(2)), pick_time(),
                   1'($urandom), pick_lapse());
      send_item(CMD_TICK, ID_W'($urandom), pick_time(), pick_time(), 1'($urandom),
                ELAPSED_W'($urandom_range(65535, 3)));
   endtask

   // drop valid and let the last accepted beat be noted before draining
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (bank.due_beats.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_item(CMD_QUERY, 0, '0, '0, 1'b0, '0);
      send_item(CMD_STOP, 5, '0, '0, 1'b0, '0);          // stop on an empty slot
      send_item(CMD_TICK, 0, '0, '0, 1'b0, '0);          // tick on an empty bank
      send_item(CMD_START, 0, '0, '0, 1'b0, '0);
      send_item(CMD_START, 0, 5, 5, 1'b1, '0);           // already active
      send_item(CMD_START, 31, '1, '1, 1'b1, '1);
      send_item(CMD_START, 1, 5, 3, 1'b1, '0);
      send_item(CMD_QUERY, 31, '0, '0, 1'b0, '0);
      send_item(CMD_STOP, 1, '0, '0, 1'b0, '0);
      send_item(CMD_START, 1, 7, 7, 1'b0, '0);           // marked for removal
      send_item(CMD_QUERY, 1, '0, '0, 1'b0, '0);
      send_item(CMD_STOP, 1, '0, '0, 1'b0, '0);          // already marked
      send_item(CMD_TICK, 0, '0, '0, 1'b0, '0);          // zero left is not yet expired
      send_item(CMD_TICK, 0, '0, '0, 1'b0, 1);
      send_item(CMD_START, 2, '0, '0, 1'b1, '0);
      send_item(CMD_START, 3, 10, '0, 1'b0, '0);
      send_item(CMD_START, 4, 100, '1, 1'b1, '0);
      send_item(CMD_TICK, 0, '0, '0, 1'b0, '1);
      send_item(CMD_TICK, 0, '0, '0, 1'b0, '1);          // periodic with no interval stays due
      send_item(CMD_QUERY, 3, '0, '0, 1'b0, '0);
      send_item(CMD_STOP, 31, '0, '0, 1'b0, '0);
      send_item(CMD_TICK, 0, '0, '0, 1'b0, 16'h5555);
      send_item(CMD_QUERY, 31, '0, '0, 1'b0, '0);
      settle();

      items_sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = (phase == 1) ? 60 : (phase == 3) ? 26 : 0;
         stall_pct = (phase == 2) ? 60 : (phase == 3) ? 26 : 0;
         if (phase == 0) begin
            // hold the receiver off so the output backs up into the input
            hold_asked <= hold_asked + 1;
            fill_bank();
         end
         if (phase == 2) fill_bank();
         while (items_sent < (phase + 1) * RANDOM_ITEMS / 4) send_random();
         settle();
      end

      if (bank.mismatches == 0 && bank.due_beats.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/stb_pkg.sv
rtl/core/stb_timer_cell.sv
rtl/core/software_timer_bank_core.sv
verif/testbench.sv
